[hdl/tsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle screen clipper package
// Shared types, constants and helpers of the triangle screen clipper.
// ----------------------------------------------------------------------------
package tsc_pkg;

	localparam int MAX_CLIPPED_VERTICES = 7;
	localparam int ATTRIBUTE_COUNT      = 4;
	localparam int ATTR_SLOTS           = 4;
	localparam int POS_W                = 24;
	localparam int ATTR_W               = 32;
	localparam int CFG_W                = 13;
	localparam int RAM_DEPTH            = 2 * MAX_CLIPPED_VERTICES;
	localparam int ADDR_W               = $clog2(RAM_DEPTH);
	localparam int CNT_W                = $clog2(MAX_CLIPPED_VERTICES + 1);
	localparam int WORK_W               = 26;
	localparam int MAG_W                = 25;
	localparam int DIFF_W               = 33;
	localparam int PROD_W               = DIFF_W + MAG_W;
	localparam int QUO_W                = DIFF_W + 1;
	localparam int DIV_STEPS            = DIFF_W;
	localparam int STEP_W               = $clog2(DIV_STEPS);

	// Per border pass: clipped axis (1 = y) and side (1 = visible below border).
	// Passes run top, right, bottom, left.
	localparam logic [3:0] PASS_AXIS  = 4'b0101;
	localparam logic [3:0] PASS_BELOW = 4'b0110;
	localparam logic [1:0] PASS_TOP    = 2'd0;
	localparam logic [1:0] PASS_RIGHT  = 2'd1;
	localparam logic [1:0] PASS_BOTTOM = 2'd2;
	localparam logic [1:0] PASS_LEFT   = 2'd3;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [POS_W-1:0]                   x;
		logic [POS_W-1:0]                   y;
		logic [ATTR_SLOTS-1:0][ATTR_W-1:0] attr;
	} vtx_t;

	localparam int VTX_W = $bits(vtx_t);

	// Request to and response from the shared multiply-divide unit.
	typedef struct packed {
		logic                     start;
		logic signed [DIFF_W-1:0] diff;
		logic [MAG_W-1:0]         num;
		logic [MAG_W-1:0]         den;
	} md_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [QUO_W-1:0] quot;
	} md_rsp_t;

	typedef enum logic [2:0] {
		MD_IDLE,
		MD_MUL,
		MD_INIT,
		MD_DIV,
		MD_FIN
	} md_state_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_SORT01,
		ST_SORT02,
		ST_SORT12,
		ST_CLASS,
		ST_FILL,
		ST_PSTART,
		ST_PRD1,
		ST_PRD2,
		ST_PVIS,
		ST_PCHK,
		ST_XNORM,
		ST_XGO,
		ST_XWAIT,
		ST_XWR,
		ST_ERD,
		ST_ELD,
		ST_EWAIT,
		ST_CULL
	} ctl_state_t;

	// Sign-extend a position to the working width.
	function automatic logic signed [WORK_W-1:0] sx_pos(input logic [POS_W-1:0] v);
		return {{(WORK_W-POS_W){v[POS_W-1]}}, v};
	endfunction

endpackage

[hdl/tsc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/tsc_muldiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply-divide unit
// Computes floor(diff * num / den) with one multiply and a restoring divide
// that yields one quotient bit per cycle. Requires 0 <= num <= den, den > 0.
// ----------------------------------------------------------------------------
module tsc_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  tsc_pkg::md_req_t  req,
	output tsc_pkg::md_rsp_t  rsp
);
	import tsc_pkg::*;

	md_state_t st_q, st_d;

	logic [DIFF_W-1:0]       mag_q;
	logic [MAG_W-1:0]        num_q;
	logic [MAG_W-1:0]        den_q;
	logic                    neg_q;
	logic [PROD_W-1:0]       prod_q;
	logic [MAG_W-1:0]        rem_q;
	logic [DIFF_W-1:0]       sh_q;
	logic [STEP_W-1:0]       cnt_q;
	logic signed [QUO_W-1:0] quot_q;
	logic                    done_q;

	logic [DIFF_W-1:0] diff_mag;
	logic [MAG_W:0]    trial;
	logic              ge;
	logic [MAG_W:0]    rem_next;
	logic [QUO_W-1:0]  q_up;

	// Magnitude of the signed operand, and one restoring step.
	always_comb begin
		diff_mag = req.diff[DIFF_W-1] ? DIFF_W'(-req.diff) : DIFF_W'(req.diff);
		trial    = {rem_q, sh_q[DIFF_W-1]};
		ge       = trial >= {1'b0, den_q};
		rem_next = ge ? (trial - {1'b0, den_q}) : trial;
		q_up     = {1'b0, sh_q} + QUO_W'(rem_q != '0);
	end

	// Sequencer of the unit.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			MD_IDLE: if (req.start) st_d = MD_MUL;
			MD_MUL:  st_d = MD_INIT;
			MD_INIT: st_d = MD_DIV;
			MD_DIV:  if (cnt_q == STEP_W'(DIV_STEPS - 1)) st_d = MD_FIN;
			MD_FIN:  st_d = MD_IDLE;
			default: st_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= MD_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == MD_FIN);
			if (st_q == MD_INIT) begin
				cnt_q <= '0;
			end else if (st_q == MD_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Operand capture, product, divide steps and signed floor correction.
	always_ff @(posedge clk) begin
		unique case (st_q)
			MD_IDLE: begin
				if (req.start) begin
					mag_q <= diff_mag;
					num_q <= req.num;
					den_q <= req.den;
					neg_q <= req.diff[DIFF_W-1];
				end
			end
			MD_MUL: prod_q <= PROD_W'(mag_q) * PROD_W'(num_q);
			MD_INIT: begin
				rem_q <= prod_q[PROD_W-1:DIFF_W];
				sh_q  <= prod_q[DIFF_W-1:0];
			end
			MD_DIV: begin
				rem_q <= rem_next[MAG_W-1:0];
				sh_q  <= {sh_q[DIFF_W-2:0], ge};
			end
			MD_FIN: quot_q <= neg_q ? -$signed(q_up) : $signed({1'b0, sh_q});
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

[hdl/triangle_screen_clipper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle screen clipper
// Sorts a triangle by y, culls or passes it, or clips it against the screen.
// ----------------------------------------------------------------------------
// Usage:
// Vertices arrive on the input channel, one word each; every third word
// completes a triangle. in_ready stays high after the first two. After the third
// the block drops in_ready until every result word of the triangle is taken.
// Results leave on the output channel, one polygon vertex per word, with
// last_vertex set on the final one; a culled or fully clipped triangle gives
// a single word with polygon_size 0 and zeroed fields.
// A culled triangle goes from the y sort and classification straight to its
// output word, and a triangle wholly on screen skips the border passes.
// Clipping walks four border passes over the vertex memory, edge by edge;
// each border crossing takes five quotients on the shared multiply-divide
// unit.
// Reset empties the vertex collection, restores a 640 by 480 screen and drops
// out_valid. A stalled receiver simply holds the current word and the block.
// Screen size may be written whenever the block is idle.
// ----------------------------------------------------------------------------
module triangle_screen_clipper (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [tsc_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [tsc_pkg::POS_W-1:0]  pos_x,
	input  logic signed [tsc_pkg::POS_W-1:0]  pos_y,
	input  logic signed [tsc_pkg::ATTR_W-1:0] attr_zero,
	input  logic signed [tsc_pkg::ATTR_W-1:0] attr_one,
	input  logic signed [tsc_pkg::ATTR_W-1:0] attr_two,
	input  logic signed [tsc_pkg::ATTR_W-1:0] attr_three,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tsc_pkg::POS_W-1:0]  out_x,
	output logic signed [tsc_pkg::POS_W-1:0]  out_y,
	output logic signed [tsc_pkg::ATTR_W-1:0] out_attr_zero,
	output logic signed [tsc_pkg::ATTR_W-1:0] out_attr_one,
	output logic signed [tsc_pkg::ATTR_W-1:0] out_attr_two,
	output logic signed [tsc_pkg::ATTR_W-1:0] out_attr_three,
	output logic [2:0]                        polygon_size,
	output logic                              last_vertex
);
	import tsc_pkg::*;

	ctl_state_t st_q, st_d;

	// Control registers.
	logic [CFG_W-1:0] width_q, height_q;
	logic [1:0]       load_q;
	logic [1:0]       pass_q;
	logic             bank_q;
	logic [CNT_W-1:0] n_q, m_q, i_q;
	logic [2:0]       j_q;
	logic             inside_q;
	logic             out_valid_q;
	logic             last_q;

	// Payload registers.
	vtx_t             vin_q [3];
	vtx_t             v1_q, v2_q, cv_q;
	logic [MAG_W-1:0] num_q, den_q;
	vtx_t             out_q;
	logic [2:0]       size_q;

	// Memory ports and unit handshake.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	vtx_t              ram_wdata;
	logic [VTX_W-1:0]  ram_rdata;
	vtx_t              rd_vtx;
	md_req_t           md_req;
	md_rsp_t           md_rsp;

	// Datapath wires.
	vtx_t                     in_vtx;
	logic                     in_acc;
	logic signed [WORK_W-1:0] w_b, h_b, border;
	logic signed [WORK_W-1:0] x0, x1, x2, minx, maxx, miny, maxy;
	logic                     cull, on_screen;
	logic                     axis, below;
	logic signed [WORK_W-1:0] c1, c2, o1, o2, num_s, den_s;
	logic                     vis1, vis2;
	logic [ADDR_W-1:0]        src_base, dst_base;
	logic [CNT_W-1:0]         i_next;
	logic [1:0]               aidx;
	logic signed [WORK_W-1:0] o_sum;

	assign rd_vtx = vtx_t'(ram_rdata);

	tsc_ram #(
		.WIDTH(VTX_W),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tsc_muldiv u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.rsp   (md_rsp)
	);

	// Incoming vertex with unused attribute slots forced to zero.
	always_comb begin
		in_vtx.x = pos_x;
		in_vtx.y = pos_y;
		in_vtx.attr[0] = attr_zero;
		in_vtx.attr[1] = attr_one;
		in_vtx.attr[2] = attr_two;
		in_vtx.attr[3] = attr_three;
		for (int a = 0; a < ATTR_SLOTS; a++) begin
			if (a >= ATTRIBUTE_COUNT) begin
				in_vtx.attr[a] = '0;
			end
		end
	end

	assign in_ready = (st_q == ST_LOAD);
	assign in_acc   = in_valid && in_ready;

	// Borders and bounding box classification of the sorted triangle.
	always_comb begin
		w_b  = $signed({{(WORK_W-CFG_W-8){1'b0}}, width_q, 8'd0});
		h_b  = $signed({{(WORK_W-CFG_W-8){1'b0}}, height_q, 8'd0});
		x0   = sx_pos(vin_q[0].x);
		x1   = sx_pos(vin_q[1].x);
		x2   = sx_pos(vin_q[2].x);
		minx = (x1 < x0) ? x1 : x0;
		minx = (x2 < minx) ? x2 : minx;
		maxx = (x1 > x0) ? x1 : x0;
		maxx = (x2 > maxx) ? x2 : maxx;
		miny = sx_pos(vin_q[0].y);
		maxy = sx_pos(vin_q[2].y);
		cull      = (minx > w_b) || (maxx < 0) || (miny > h_b) || (maxy < 0);
		on_screen = (minx > 0) && (maxx < w_b) && (miny > 0) && (maxy < h_b);
	end

	// Edge visibility and crossing operands for the current pass.
	always_comb begin
		axis  = PASS_AXIS[pass_q];
		below = PASS_BELOW[pass_q];
		priority case (pass_q)
			PASS_RIGHT:  border = w_b;
			PASS_BOTTOM: border = h_b;
			default:     border = '0;
		endcase
		c1 = axis ? sx_pos(v1_q.y) : sx_pos(v1_q.x);
		c2 = axis ? sx_pos(v2_q.y) : sx_pos(v2_q.x);
		o1 = axis ? sx_pos(v1_q.x) : sx_pos(v1_q.y);
		o2 = axis ? sx_pos(v2_q.x) : sx_pos(v2_q.y);
		vis1 = below ? (c1 < border) : (c1 > border);
		vis2 = below ? (c2 < border) : (c2 > border);
		num_s = border - c1;
		den_s = c2 - c1;
		src_base = bank_q ? ADDR_W'(MAX_CLIPPED_VERTICES) : '0;
		dst_base = bank_q ? '0 : ADDR_W'(MAX_CLIPPED_VERTICES);
		i_next   = (i_q + 1'b1 == n_q) ? '0 : i_q + 1'b1;
		aidx     = 2'(j_q - 3'd1);
		o_sum    = o1 + WORK_W'(md_rsp.quot);
	end

	// Request to the shared unit: other axis first, then each attribute.
	always_comb begin
		md_req.start = (st_q == ST_XGO);
		md_req.num   = num_q;
		md_req.den   = den_q;
		if (j_q == '0) begin
			md_req.diff = DIFF_W'(o2 - o1);
		end else begin
			md_req.diff = $signed({v2_q.attr[aidx][ATTR_W-1], v2_q.attr[aidx]})
				- $signed({v1_q.attr[aidx][ATTR_W-1], v1_q.attr[aidx]});
		end
	end

	// Memory port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dst_base + ADDR_W'(m_q);
		ram_wdata = cv_q;
		ram_raddr = src_base + ADDR_W'(i_q);
		unique case (st_q)
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(i_q);
				ram_wdata = vin_q[i_q[1:0]];
			end
			ST_PVIS: begin
				ram_we    = vis1 && (m_q < CNT_W'(MAX_CLIPPED_VERTICES));
				ram_wdata = v1_q;
			end
			ST_XWR:  ram_we = 1'b1;
			ST_PRD1: ram_raddr = src_base + ADDR_W'(i_next);
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_LOAD:   if (in_acc && load_q == 2'd2) st_d = ST_SORT01;
			ST_SORT01: st_d = ST_SORT02;
			ST_SORT02: st_d = ST_SORT12;
			ST_SORT12: st_d = ST_CLASS;
			ST_CLASS:  st_d = cull ? ST_CULL : ST_FILL;
			ST_FILL: begin
				if (i_q == CNT_W'(2)) st_d = inside_q ? ST_ERD : ST_PSTART;
			end
			ST_PSTART: begin
				if (i_q != n_q) begin
					st_d = ST_PRD1;
				end else if (pass_q == PASS_LEFT) begin
					st_d = (m_q == '0) ? ST_CULL : ST_ERD;
				end
			end
			ST_PRD1: st_d = ST_PRD2;
			ST_PRD2: st_d = ST_PVIS;
			ST_PVIS: st_d = ST_PCHK;
			ST_PCHK: begin
				st_d = ((vis1 != vis2) && (m_q < CNT_W'(MAX_CLIPPED_VERTICES)))
					? ST_XNORM : ST_PSTART;
			end
			ST_XNORM: st_d = ST_XGO;
			ST_XGO:   st_d = ST_XWAIT;
			ST_XWAIT: begin
				if (md_rsp.done) st_d = (j_q == 3'd4) ? ST_XWR : ST_XGO;
			end
			ST_XWR:  st_d = ST_PSTART;
			ST_ERD:  st_d = ST_ELD;
			ST_ELD:  st_d = ST_EWAIT;
			ST_EWAIT: begin
				if (out_ready) st_d = last_q ? ST_LOAD : ST_ERD;
			end
			ST_CULL: st_d = ST_EWAIT;
			default: st_d = ST_LOAD;
		endcase
	end

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_LOAD;
			width_q     <= CFG_W'(640);
			height_q    <= CFG_W'(480);
			load_q      <= '0;
			pass_q      <= '0;
			bank_q      <= 1'b0;
			n_q         <= '0;
			m_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default:    ;
				endcase
			end
			unique case (st_q)
				ST_LOAD: begin
					if (in_acc) load_q <= (load_q == 2'd2) ? 2'd0 : load_q + 1'b1;
				end
				ST_CLASS: begin
					inside_q <= on_screen;
					i_q      <= '0;
				end
				ST_FILL: begin
					if (i_q == CNT_W'(2)) begin
						i_q    <= '0;
						n_q    <= CNT_W'(3);
						m_q    <= '0;
						bank_q <= 1'b0;
						pass_q <= PASS_TOP;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_PSTART: begin
					if (i_q == n_q) begin
						n_q    <= m_q;
						m_q    <= '0;
						i_q    <= '0;
						bank_q <= ~bank_q;
						pass_q <= pass_q + 1'b1;
					end
				end
				ST_PVIS: begin
					if (vis1 && (m_q < CNT_W'(MAX_CLIPPED_VERTICES))) m_q <= m_q + 1'b1;
				end
				ST_PCHK: begin
					if (!((vis1 != vis2) && (m_q < CNT_W'(MAX_CLIPPED_VERTICES)))) begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_XNORM: j_q <= '0;
				ST_XWAIT: if (md_rsp.done) j_q <= j_q + 1'b1;
				ST_XWR: begin
					m_q <= m_q + 1'b1;
					i_q <= i_q + 1'b1;
				end
				ST_ELD: begin
					out_valid_q <= 1'b1;
					last_q      <= (i_q == n_q - 1'b1);
				end
				ST_CULL: begin
					out_valid_q <= 1'b1;
					last_q      <= 1'b1;
				end
				ST_EWAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						i_q         <= i_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Vertex capture, y sort, edge endpoints, crossing vertex and output word.
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_LOAD: if (in_acc) vin_q[load_q] <= in_vtx;
			ST_SORT01: begin
				if ($signed(vin_q[0].y) > $signed(vin_q[1].y)) begin
					vin_q[0] <= vin_q[1];
					vin_q[1] <= vin_q[0];
				end
			end
			ST_SORT02: begin
				if ($signed(vin_q[0].y) > $signed(vin_q[2].y)) begin
					vin_q[0] <= vin_q[2];
					vin_q[2] <= vin_q[0];
				end
			end
			ST_SORT12: begin
				if ($signed(vin_q[1].y) > $signed(vin_q[2].y)) begin
					vin_q[1] <= vin_q[2];
					vin_q[2] <= vin_q[1];
				end
			end
			ST_PRD1: v1_q <= rd_vtx;
			ST_PRD2: v2_q <= rd_vtx;
			ST_XNORM: begin
				num_q <= den_s[WORK_W-1] ? MAG_W'(-num_s) : MAG_W'(num_s);
				den_q <= den_s[WORK_W-1] ? MAG_W'(-den_s) : MAG_W'(den_s);
				if (axis) begin
					cv_q.y <= POS_W'(border);
				end else begin
					cv_q.x <= POS_W'(border);
				end
			end
			ST_XWAIT: begin
				if (md_rsp.done) begin
					if (j_q == '0) begin
						if (axis) begin
							cv_q.x <= {o_sum[POS_W-1:8], 8'd0};
						end else begin
							cv_q.y <= {o_sum[POS_W-1:8], 8'd0};
						end
					end else begin
						cv_q.attr[aidx] <= v1_q.attr[aidx] + md_rsp.quot[ATTR_W-1:0];
					end
				end
			end
			ST_ELD: begin
				out_q  <= rd_vtx;
				size_q <= 3'(n_q);
			end
			ST_CULL: begin
				out_q  <= '0;
				size_q <= '0;
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign out_x          = out_q.x;
	assign out_y          = out_q.y;
	assign out_attr_zero  = out_q.attr[0];
	assign out_attr_one   = out_q.attr[1];
	assign out_attr_two   = out_q.attr[2];
	assign out_attr_three = out_q.attr[3];
	assign polygon_size   = size_q;
	assign last_vertex    = last_q;

`ifndef NO_ASSERTIONS
	// The block never takes vertices while a result word is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while a result is pending");

	// An empty polygon is always a single, final word.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && polygon_size == 3'd0) |-> last_vertex)
		else $error("empty polygon word not marked last");

	// After the final word of a triangle is taken the block takes vertices again.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_vertex) |=> (in_ready && !out_valid))
		else $error("block did not return to vertex collection");
`endif

endmodule

[test/triangle_screen_clipper_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle screen clipper testbench
// Feeds triangles as vertex words through a queue-fed driver, predicts every
// polygon vertex with a behavioral clipper and checks each output word in
// order. Runs several screen sizes, random stalls on both channels and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module triangle_screen_clipper_tb;
	import tsc_pkg::*;

	typedef struct {
		logic [POS_W-1:0]                  x;
		logic [POS_W-1:0]                  y;
		logic [ATTR_SLOTS-1:0][ATTR_W-1:0] attr;
	} vertex_word_t;

	typedef struct {
		logic [POS_W-1:0]                  x;
		logic [POS_W-1:0]                  y;
		logic [ATTR_SLOTS-1:0][ATTR_W-1:0] attr;
		logic [2:0]                        size;
		logic                              last;
	} poly_vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [POS_W-1:0] pos_x = '0, pos_y = '0;
	logic signed [ATTR_W-1:0] attr_zero = '0, attr_one = '0, attr_two = '0, attr_three = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [POS_W-1:0] out_x, out_y;
	logic signed [ATTR_W-1:0] out_attr_zero, out_attr_one, out_attr_two, out_attr_three;
	logic [2:0] polygon_size;
	logic last_vertex;

	triangle_screen_clipper dut (.*);

	vertex_word_t vertex_queue[$];
	poly_vertex_t expected_vertices[$];

	// Predictor state: screen size and the two vertex banks.
	logic [CFG_W-1:0] screen_w = 13'd640;
	logic [CFG_W-1:0] screen_h = 13'd480;
	int     vertices_held = 0;
	longint bank_x[RAM_DEPTH];
	longint bank_y[RAM_DEPTH];
	longint bank_attr[RAM_DEPTH][ATTR_SLOTS];

	int  errors = 0;
	int  triangles_done = 0;
	int  words_checked = 0;
	int  culled_words = 0;
	bit  run_started = 0;
	bit  word_taken = 0;
	bit  quiet = 0;
	int  in_gap = 0;
	int  out_gap = 0;
	int  hold_cycles = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && ((a < 0) != (b < 0)))
			q--;
		return q;
	endfunction

	function automatic longint axis_coord(int slot, bit axis);
		return axis ? bank_y[slot] : bank_x[slot];
	endfunction

	task automatic copy_slot(int dst, int src);
		bank_x[dst] = bank_x[src];
		bank_y[dst] = bank_y[src];
		for (int a = 0; a < ATTR_SLOTS; a++)
			bank_attr[dst][a] = bank_attr[src][a];
	endtask

	task automatic swap_slots(int p, int q);
		longint t;
		t = bank_x[p]; bank_x[p] = bank_x[q]; bank_x[q] = t;
		t = bank_y[p]; bank_y[p] = bank_y[q]; bank_y[q] = t;
		for (int a = 0; a < ATTR_SLOTS; a++) begin
			t = bank_attr[p][a]; bank_attr[p][a] = bank_attr[q][a]; bank_attr[q][a] = t;
		end
	endtask

	// One border pass: reads n vertices at src, writes the clipped ring at dst.
	task automatic clip_border(input logic [1:0] pass, input int src, input int dst,
			inout int n);
		bit axis, below, vis1, vis2;
		longint border, v1, v2, num, den, o1, o2, o;
		int m, s1, s2, d;
		axis = PASS_AXIS[pass];
		below = PASS_BELOW[pass];
		border = (pass == PASS_RIGHT) ? longint'(screen_w) * 256 :
			(pass == PASS_BOTTOM) ? longint'(screen_h) * 256 : 0;
		m = 0;
		for (int i = 0; i < n; i++) begin
			s1 = src + i;
			s2 = src + ((i + 1) % n);
			v1 = axis_coord(s1, axis);
			v2 = axis_coord(s2, axis);
			vis1 = below ? (v1 < border) : (v1 > border);
			vis2 = below ? (v2 < border) : (v2 > border);
			if (vis1 && m < MAX_CLIPPED_VERTICES) begin
				copy_slot(dst + m, s1);
				m++;
			end
			if (vis1 != vis2 && m < MAX_CLIPPED_VERTICES) begin
				d = dst + m;
				num = border - v1;
				den = v2 - v1;
				o1 = axis_coord(s1, !axis);
				o2 = axis_coord(s2, !axis);
				// The crossing lands on the border; the other axis is floored to a pixel.
				o = o1 + floor_div((o2 - o1) * num, den);
				o = o & ~longint'(255);
				if (axis) begin
					bank_y[d] = border;
					bank_x[d] = o;
				end else begin
					bank_x[d] = border;
					bank_y[d] = o;
				end
				for (int a = 0; a < ATTR_SLOTS; a++)
					bank_attr[d][a] = bank_attr[s1][a] +
						floor_div((bank_attr[s2][a] - bank_attr[s1][a]) * num, den);
				m++;
			end
		end
		n = m;
	endtask

	// Takes one vertex word; on the third one predicts the polygon it yields.
	task automatic predict_polygon(vertex_word_t v);
		int slot, n, bank, next;
		longint minx, maxx, miny, maxy, w, h;
		poly_vertex_t e;
		slot = vertices_held;
		bank_x[slot] = longint'($signed(v.x));
		bank_y[slot] = longint'($signed(v.y));
		for (int a = 0; a < ATTR_SLOTS; a++)
			bank_attr[slot][a] = (a < ATTRIBUTE_COUNT) ? longint'($signed(v.attr[a])) : 0;
		if (slot < 2) begin
			vertices_held = slot + 1;
			return;
		end
		vertices_held = 0;
		triangles_done++;

		minx = bank_x[0];
		maxx = minx;
		for (int k = 1; k < 3; k++) begin
			if (bank_x[k] < minx) minx = bank_x[k];
			if (bank_x[k] > maxx) maxx = bank_x[k];
		end
		// Sort by y as the design does: swap only on strictly greater.
		if (bank_y[0] > bank_y[1]) swap_slots(0, 1);
		if (bank_y[0] > bank_y[2]) swap_slots(0, 2);
		if (bank_y[1] > bank_y[2]) swap_slots(1, 2);
		miny = bank_y[0];
		maxy = bank_y[2];

		w = longint'(screen_w) * 256;
		h = longint'(screen_h) * 256;
		bank = 0;
		n = 3;
		if (minx > w || maxx < 0 || miny > h || maxy < 0) begin
			n = 0;
		end else if (!(minx > 0 && maxx < w && miny > 0 && maxy < h)) begin
			for (int p = 0; p < 4; p++) begin
				next = bank ? 0 : MAX_CLIPPED_VERTICES;
				clip_border(p[1:0], bank, next, n);
				bank = next;
			end
		end

		if (n == 0) begin
			e.x = '0;
			e.y = '0;
			e.attr = '0;
			e.size = '0;
			e.last = 1'b1;
			expected_vertices.push_back(e);
			return;
		end
		for (int k = 0; k < n; k++) begin
			e.x = bank_x[bank + k][POS_W-1:0];
			e.y = bank_y[bank + k][POS_W-1:0];
			for (int a = 0; a < ATTR_SLOTS; a++)
				e.attr[a] = bank_attr[bank + k][a][ATTR_W-1:0];
			e.size = n[2:0];
			e.last = (k == n - 1);
			expected_vertices.push_back(e);
		end
	endtask

	// Input side: a word is taken at the edge where valid and ready meet.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_polygon(vertex_queue.pop_front());
			word_taken = 1;
		end
	end

	// Vertex driver: holds a word until taken, then idles in random bursts.
	always @(negedge clk) begin
		if (run_started && !(in_valid && !word_taken)) begin
			if (word_taken && !quiet && $urandom_range(0, 3) == 0)
				in_gap = $urandom_range(1, 5);
			word_taken = 0;
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (vertex_queue.size() > 0) begin
				pos_x <= vertex_queue[0].x;
				pos_y <= vertex_queue[0].y;
				attr_zero <= vertex_queue[0].attr[0];
				attr_one <= vertex_queue[0].attr[1];
				attr_two <= vertex_queue[0].attr[2];
				attr_three <= vertex_queue[0].attr[3];
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a long hold-off when asked, otherwise short random stalls.
	always @(negedge clk) begin
		if (run_started) begin
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0)
					out_gap = $urandom_range(1, 5);
			end
		end
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endtask

	// Result monitor: every output word against the oldest prediction.
	always @(posedge clk) begin
		poly_vertex_t e;
		if (out_valid && out_ready) begin
			if (expected_vertices.size() == 0) begin
				$error("output word with no prediction pending");
				errors++;
			end else begin
				e = expected_vertices.pop_front();
				words_checked++;
				if (e.size == 0)
					culled_words++;
				check_field("out_x", $signed(e.x), out_x);
				check_field("out_y", $signed(e.y), out_y);
				check_field("out_attr_zero", $signed(e.attr[0]), out_attr_zero);
				check_field("out_attr_one", $signed(e.attr[1]), out_attr_one);
				check_field("out_attr_two", $signed(e.attr[2]), out_attr_two);
				check_field("out_attr_three", $signed(e.attr[3]), out_attr_three);
				check_field("polygon_size", e.size, polygon_size);
				check_field("last_vertex", e.last, last_vertex);
			end
		end
	end

	task automatic push_vertex(int x, int y, int a0, int a1, int a2, int a3);
		vertex_word_t v;
		v.x = x[POS_W-1:0];
		v.y = y[POS_W-1:0];
		v.attr[0] = a0;
		v.attr[1] = a1;
		v.attr[2] = a2;
		v.attr[3] = a3;
		vertex_queue.push_back(v);
	endtask

	// Positions mostly around the screen, some on the border, some anywhere.
	function automatic int rand_pos(int lim);
		int r;
		case ($urandom_range(0, 9))
			0: r = $signed($urandom() << 8) >>> 8;
			1: r = $urandom_range(0, 1) ? lim : 0;
			default: r = int'($urandom_range(0, 2 * lim + 2048)) - lim / 2 - 1024;
		endcase
		return r;
	endfunction

	function automatic int rand_attr();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	task automatic push_random_triangles(int count);
		for (int t = 0; t < count * 3; t++)
			push_vertex(rand_pos(int'(screen_w) * 256), rand_pos(int'(screen_h) * 256),
				rand_attr(), rand_attr(), rand_attr(), rand_attr());
	endtask

	task automatic wait_idle();
		while (vertex_queue.size() > 0 || in_valid || expected_vertices.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_screen(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		screen_w = w;
		screen_h = h;
	endtask

	initial begin
		logic [CFG_W-1:0] sizes_w[5];
		logic [CFG_W-1:0] sizes_h[5];
		sizes_w = '{13'd640, 13'd1, 13'd4096, 13'd8191, 13'd0};
		sizes_h = '{13'd480, 13'd1, 13'd4096, 13'd0, 13'd8191};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_started = 1;

		// Directed triangles at the reset screen size of 640 by 480.
		push_vertex(100 * 256, 100 * 256, 32'h7FFF_FFFF, 32'h8000_0000, 0, -1);
		push_vertex(200 * 256, 300 * 256, 32'h8000_0000, 32'h7FFF_FFFF, -1, 0);
		push_vertex(50 * 256 + 17, 200 * 256 + 255, 1, 2, 3, 4);
		push_vertex(700 * 256, 10 * 256, 1, 1, 1, 1);
		push_vertex(800 * 256, 20 * 256, 2, 2, 2, 2);
		push_vertex(900 * 256, 30 * 256, 3, 3, 3, 3);
		push_vertex(10 * 256, -5, 0, 0, 0, 0);
		push_vertex(20 * 256, -256, 0, 0, 0, 0);
		push_vertex(30 * 256, -1, 0, 0, 0, 0);
		push_vertex(-8388608, -8388608, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_vertex(-8388608, -8388608, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_vertex(-8388608, -8388608, 0, 0, 0, 0);
		push_vertex(8388607, 8388607, -1, -1, -1, -1);
		push_vertex(8388607, 8388607, 0, 0, 0, 0);
		push_vertex(8388607, 8388607, 1, 1, 1, 1);
		// Covers the whole screen, so every border cuts it.
		push_vertex(-1000 * 256, -1000 * 256, 32'h8000_0000, 32'h7FFF_FFFF, 0, 65536);
		push_vertex(5000 * 256, -500 * 256, 32'h7FFF_FFFF, 32'h8000_0000, -65536, 0);
		push_vertex(-800 * 256, 4000 * 256 + 77, 12345, -54321, 32'h7FFF_FFFF, 32'h8000_0000);
		// Vertices exactly on the borders, with equal y to exercise the sort on ties.
		push_vertex(640 * 256, 0, 5, 6, 7, 8);
		push_vertex(0, 0, 9, 10, 11, 12);
		push_vertex(320 * 256, 480 * 256, 13, 14, 15, 16);
		// Crosses only the top border, with fractional positions.
		push_vertex(300 * 256 + 128, -20 * 256 - 64, 1000, -1000, 65536, -65536);
		push_vertex(100 * 256 + 3, 50 * 256 + 200, -7, 7, 0, 99);
		push_vertex(500 * 256 + 250, 60 * 256 + 1, 32'h4000_0000, -5, 3, 32'hC000_0000);
		push_random_triangles(14);

		for (int p = 1; p < 6; p++) begin
			wait_idle();
			if (p == 5) begin
				write_screen(CFG_W'($urandom_range(1, 4096)), CFG_W'($urandom_range(1, 4096)));
				quiet = 1;
			end else begin
				write_screen(sizes_w[p], sizes_h[p]);
			end
			// Long receiver hold-off so the block fills and stalls its input.
			if (p == 2)
				hold_cycles = 400;
			push_random_triangles(p == 5 ? 10 : 12);
		end

		wait_idle();
		if (expected_vertices.size() > 0) begin
			$error("%0d predicted words never arrived", expected_vertices.size());
			errors++;
		end
		$display("Ran %0d triangles over six screen sizes; %0d output words checked.",
			triangles_done, words_checked);
		$display("%0d of them were culled or fully clipped away.", culled_words);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog for a stuck handshake.
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
